### hw/rtl/xcs_pkg.sv
// package for the xmodem checksum sender
// frame characters, buffer geometry, op and phase codes and limits; no dependencies

package xcs_pkg;

   localparam int BLOCK_BYTES = 128;
   localparam int ADDR_W      = $clog2(BLOCK_BYTES);
   localparam int CNT_W       = $clog2(BLOCK_BYTES + 4);

   localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(BLOCK_BYTES + 3);
   localparam logic [CNT_W-1:0] DATA_START = CNT_W'(3);
   localparam logic [CNT_W-1:0] FILL_FULL  = CNT_W'(BLOCK_BYTES);

   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_EOT = 8'h04;

   localparam logic [1:0] OP_RX      = 2'd0;
   localparam logic [1:0] OP_TIMEOUT = 2'd1;
   localparam logic [1:0] OP_FILE    = 2'd2;
   localparam logic [1:0] OP_SLOT    = 2'd3;

   localparam logic [2:0] PH_WAIT_START = 3'd0;
   localparam logic [2:0] PH_FILL       = 3'd1;
   localparam logic [2:0] PH_SEND       = 3'd2;
   localparam logic [2:0] PH_WAIT_ACK   = 3'd3;
   localparam logic [2:0] PH_EOT        = 3'd4;
   localparam logic [2:0] PH_FINAL      = 3'd5;
   localparam logic [2:0] PH_DONE       = 3'd6;

   localparam logic [1:0]  EOT_REPEAT = 2'd3;
   localparam logic [15:0] RETRY_MAX  = 16'hFFFF;

endpackage

### hw/rtl/xmodem_checksum_sender_unit.sv
// xmodem sender with 8-bit checksum, top level
// block buffer memory, transfer control and output register; uses xcs_pkg
//
// One request per cycle while the result side takes results, one result per
// request. The frame data byte for a request is fetched from the synchronous
// block buffer memory at the same edge that takes the request; the request
// is then held in the update stage and its result is written into the output
// register. The output register lets the next request enter while a result
// waits; a stalled result stalls the update stage and then the request side.

module xmodem_checksum_sender_unit
   import xcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rx_byte[7:0], file_byte[15:8]
   input  logic [1:0]  req_tuser,  // op[1:0]
   input  logic        req_tlast,  // file_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // tx_byte[7:0], want_data[8], phase[11:9],
                                   // retries[27:12], done_res[28], zero[31:29]
   output logic        rsp_tuser,  // tx_valid
   output logic        rsp_tlast   // tx_frame_end
);

   logic [7:0]       buf_mem [BLOCK_BYTES];
   logic [7:0]       rd_data_ff;

   logic [2:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [CNT_W-1:0] send_pos_ff, send_pos_in;
   logic [7:0]       block_num_ff, block_num_in;
   logic [7:0]       checksum_ff, checksum_in;
   logic             file_fin_ff, file_fin_in;
   logic [1:0]       eot_count_ff, eot_count_in;
   logic [15:0]      retry_ff, retry_in;

   logic             x_valid_ff;
   logic [1:0]       x_op_ff;
   logic [7:0]       x_rx_ff;
   logic [7:0]       x_fb_ff;
   logic             x_last_ff;

   logic             rsp_valid_ff;
   logic [31:0]      rsp_data_ff;
   logic             rsp_user_ff;
   logic             rsp_last_ff;

   logic             out_free;
   logic             exec;
   logic             accept;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0] data_idx;
   logic [CNT_W-1:0] fill_next;
   logic [1:0]       eot_next;
   logic             tx_valid;
   logic [7:0]       tx_byte;
   logic             tx_end;
   logic [7:0]       frame_byte;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign exec       = x_valid_ff && out_free;
   assign req_tready = !x_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // data index for the current and for the next request
   assign data_idx = send_pos_ff - DATA_START;
   assign rd_addr  = ADDR_W'(send_pos_in - DATA_START);
   assign wr_addr  = fill_count_ff[ADDR_W-1:0];
   assign fill_next = fill_count_ff + CNT_W'(1);
   assign eot_next  = eot_count_ff + 2'd1;

   always_comb begin
      if (send_pos_ff == CNT_W'(0)) begin
         frame_byte = CH_SOH;
      end else if (send_pos_ff == CNT_W'(1)) begin
         frame_byte = block_num_ff;
      end else if (send_pos_ff == CNT_W'(2)) begin
         frame_byte = ~block_num_ff;
      end else if (send_pos_ff >= FRAME_LAST) begin
         frame_byte = checksum_ff;
      end else if (data_idx < fill_count_ff) begin
         frame_byte = rd_data_ff;
      end else begin
         frame_byte = 8'h00;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      fill_count_in = fill_count_ff;
      send_pos_in   = send_pos_ff;
      block_num_in  = block_num_ff;
      checksum_in   = checksum_ff;
      file_fin_in   = file_fin_ff;
      eot_count_in  = eot_count_ff;
      retry_in      = retry_ff;
      wr_en         = 1'b0;
      tx_valid      = 1'b0;
      tx_byte       = 8'h00;
      tx_end        = 1'b0;
      if (exec) begin
         case (phase_ff)
            PH_WAIT_START: begin
               if (x_op_ff == OP_RX && x_rx_ff == CH_NAK) begin
                  fill_count_in = '0;
                  checksum_in   = 8'h00;
                  phase_in      = PH_FILL;
               end
            end
            PH_FILL: begin
               if (x_op_ff == OP_FILE && fill_count_ff < FILL_FULL) begin
                  wr_en         = 1'b1;
                  fill_count_in = fill_next;
                  checksum_in   = checksum_ff + x_fb_ff;
                  if (x_last_ff) begin
                     file_fin_in = 1'b1;
                  end
                  if (x_last_ff || fill_next >= FILL_FULL) begin
                     send_pos_in = '0;
                     phase_in    = PH_SEND;
                  end
               end
            end
            PH_SEND: begin
               if (x_op_ff == OP_SLOT) begin
                  tx_valid = 1'b1;
                  tx_byte  = frame_byte;
                  if (send_pos_ff >= FRAME_LAST) begin
                     tx_end   = 1'b1;
                     phase_in = PH_WAIT_ACK;
                  end else begin
                     send_pos_in = send_pos_ff + CNT_W'(1);
                  end
               end else if (x_op_ff == OP_TIMEOUT ||
                            (x_op_ff == OP_RX && x_rx_ff != CH_ACK)) begin
                  if (retry_ff != RETRY_MAX) begin
                     retry_in = retry_ff + 16'd1;
                  end
                  send_pos_in = '0;
                  phase_in    = PH_SEND;
               end
            end
            PH_WAIT_ACK: begin
               if (x_op_ff == OP_RX && x_rx_ff == CH_ACK) begin
                  block_num_in = block_num_ff + 8'd1;
                  if (file_fin_ff) begin
                     eot_count_in = 2'd0;
                     phase_in     = PH_EOT;
                  end else begin
                     fill_count_in = '0;
                     checksum_in   = 8'h00;
                     phase_in      = PH_FILL;
                  end
               end else if (x_op_ff == OP_RX || x_op_ff == OP_TIMEOUT) begin
                  if (retry_ff != RETRY_MAX) begin
                     retry_in = retry_ff + 16'd1;
                  end
                  send_pos_in = '0;
                  phase_in    = PH_SEND;
               end
            end
            PH_EOT: begin
               if (x_op_ff == OP_SLOT) begin
                  tx_valid     = 1'b1;
                  tx_byte      = CH_EOT;
                  tx_end       = 1'b1;
                  eot_count_in = eot_next;
                  if (eot_next >= EOT_REPEAT) begin
                     phase_in = PH_FINAL;
                  end
               end
            end
            PH_FINAL: begin
               if (x_op_ff == OP_RX || x_op_ff == OP_TIMEOUT) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   // block buffer: written while filling, read when a request is taken
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[wr_addr] <= x_fb_ff;
      end
      if (accept) begin
         rd_data_ff <= buf_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT_START;
         fill_count_ff <= '0;
         send_pos_ff   <= '0;
         block_num_ff  <= 8'd1;
         checksum_ff   <= 8'h00;
         file_fin_ff   <= 1'b0;
         eot_count_ff  <= 2'd0;
         retry_ff      <= 16'd0;
         x_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         fill_count_ff <= fill_count_in;
         send_pos_ff   <= send_pos_in;
         block_num_ff  <= block_num_in;
         checksum_ff   <= checksum_in;
         file_fin_ff   <= file_fin_in;
         eot_count_ff  <= eot_count_in;
         retry_ff      <= retry_in;
         if (req_tready) begin
            x_valid_ff <= req_tvalid;
         end
         if (exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_op_ff   <= req_tuser;
         x_rx_ff   <= req_tdata[7:0];
         x_fb_ff   <= req_tdata[15:8];
         x_last_ff <= req_tlast;
      end
      if (exec) begin
         rsp_data_ff <= {3'b000, phase_in == PH_DONE, retry_in, phase_in,
                         phase_in == PH_FILL, tx_byte};
         rsp_user_ff <= tx_valid;
         rsp_last_ff <= tx_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
